// ----- design/fpm_pkg.sv -----
// fpm_pkg: shared types and constants of the fp32 multiplier
// no dependencies
package fpm_pkg;
   localparam logic [7:0]  EXP_ONES  = 8'hFF;
   localparam int          EXP_BIAS  = 127;
   localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      CLS_NORMAL = 2'd0,
      CLS_NAN    = 2'd1,
      CLS_INF    = 2'd2,
      CLS_ZERO   = 2'd3
   } class_type;

   typedef struct packed {
      class_type   cls;
      logic        sign;
      logic [23:0] mant_a;
      logic [23:0] mant_b;
      logic [9:0]  exp_sum;
   } job_type;
endpackage

// ----- design/fpm_front.sv -----
// fpm_front: accepts operands, classifies them, and holds one job for the back end
// depends on fpm_pkg
module fpm_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [31:0]     req_operand_a,
   input  logic [31:0]     req_operand_b,
   output logic            busy,
   output logic            job_valid,
   output fpm_pkg::job_type job,
   input  logic            job_take
);
   import fpm_pkg::*;

   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        a_inf, b_inf, a_zero, b_zero, any_nan;
   job_type     job_in, job_ff;
   logic        valid_ff, valid_in;

   always_comb begin
      ea = req_operand_a[30:23];
      eb = req_operand_b[30:23];
      fa = req_operand_a[22:0];
      fb = req_operand_b[22:0];
      a_inf  = (ea == EXP_ONES) && (fa == '0);
      b_inf  = (eb == EXP_ONES) && (fb == '0);
      a_zero = (ea == '0) && (fa == '0);
      b_zero = (eb == '0) && (fb == '0);
      any_nan = ((ea == EXP_ONES) && (fa != '0)) || ((eb == EXP_ONES) && (fb != '0));
      job_in.sign    = req_operand_a[31] ^ req_operand_b[31];
      job_in.mant_a  = {ea != '0, fa};
      job_in.mant_b  = {eb != '0, fb};
      job_in.exp_sum = {2'b00, ea} + {2'b00, eb};
      priority if (any_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
         job_in.cls = CLS_NAN;
      end else if (a_inf || b_inf) begin
         job_in.cls = CLS_INF;
      end else if (a_zero || b_zero) begin
         job_in.cls = CLS_ZERO;
      end else begin
         job_in.cls = CLS_NORMAL;
      end
   end

   assign busy = valid_ff;
   assign valid_in = (start && !valid_ff) ? 1'b1 : (job_take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (start && !valid_ff) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job = job_ff;
endmodule

// ----- design/fpm_back.sv -----
// fpm_back: multiplies, normalizes and rounds one job at a time
// depends on fpm_pkg
module fpm_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  fpm_pkg::job_type job,
   output logic            job_take,
   output logic            rsp_strobe,
   output logic [31:0]     rsp_product
);
   import fpm_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_NORM, S_ROUND, S_DONE} state_type;

   state_type          state_ff;
   logic [47:0]        prod_ff;
   logic signed [10:0] exp_ff;
   logic               sign_ff;
   class_type          cls_ff;
   logic               strobe_ff;
   logic [31:0]        result_ff;
   logic [47:0]        rnd;
   logic signed [10:0] exp_r;
   logic [47:0]        prod_r;

   assign job_take = (state_ff == S_IDLE) && job_valid;

   always_comb begin
      rnd = prod_ff + 48'h40_0000;
      rnd[21:0] = '0;
      prod_r = prod_ff;
      exp_r  = exp_ff;
      if (prod_ff[22]) begin
         prod_r = rnd;
         if (rnd[47]) begin
            prod_r = rnd >> 1;
            exp_r  = exp_ff + 11'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  sign_ff  <= job.sign;
                  cls_ff   <= job.cls;
                  exp_ff   <= $signed({1'b0, job.exp_sum}) - 11'sd127;
                  prod_ff  <= {24'd0, job.mant_a};
                  result_ff <= {8'd0, job.mant_b};
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff <= prod_ff[23:0] * result_ff[23:0];
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (prod_ff[47]) begin
                  prod_ff  <= prod_ff >> 1;
                  exp_ff   <= exp_ff + 11'sd1;
                  state_ff <= S_ROUND;
               end else if (!prod_ff[46] && exp_ff > 11'sd0 && cls_ff == CLS_NORMAL) begin
                  prod_ff <= prod_ff << 1;
                  exp_ff  <= exp_ff - 11'sd1;
               end else begin
                  if (exp_ff < 11'sd0) begin
                     exp_ff <= '0;
                  end
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (exp_ff < 11'sd0) begin
                  exp_ff <= '0;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
               unique case (cls_ff)
                  CLS_NAN:  result_ff <= QUIET_NAN;
                  CLS_INF:  result_ff <= {sign_ff, EXP_ONES, 23'd0};
                  CLS_ZERO: result_ff <= {sign_ff, 31'd0};
                  default: begin
                     if (exp_r >= 11'sd255) begin
                        result_ff <= {sign_ff, EXP_ONES, 23'd0};
                     end else begin
                        result_ff <= {sign_ff, exp_r[7:0], prod_r[45:23]};
                     end
                  end
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_product = result_ff;
endmodule

// ----- design/fp32_multiplier.sv -----
// fp32_multiplier: top level of the single-precision multiplier
// depends on fpm_pkg, fpm_front, fpm_back
//
// usage: drive req_operand_a/b with start high while busy is low; that
// request is taken at the clock edge. the front end holds one classified
// request; the back end multiplies it (one 24x24 product), normalizes one
// bit per cycle for subnormal inputs, rounds and shows the product on
// rsp_product with rsp_strobe high for exactly one cycle.
// the back end takes the held job in S_IDLE, then passes S_MUL, S_NORM,
// S_ROUND and S_DONE; S_NORM repeats for each left normalization step
// (up to 23, one operand subnormal) and S_ROUND repeats when a right
// normalization leaves a negative exponent. the back end's state sequence
// sets the request rate while the front end holds the next request.
// busy stays high until the back end has taken the held request.
// reset clears both ends; no request is in flight afterwards.
// the receiver cannot stall: each result must be taken in its strobe cycle.
module fp32_multiplier (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        busy,
   output logic        rsp_strobe,
   output logic [31:0] rsp_product
);
   import fpm_pkg::*;

   job_type job;
   logic    job_valid, job_take, front_busy;
   logic    back_busy_ff;

   fpm_front u_front (
      .clock, .reset, .start, .req_operand_a, .req_operand_b,
      .busy(front_busy), .job_valid, .job, .job_take
   );

   fpm_back u_back (
      .clock, .reset, .job_valid, .job, .job_take, .rsp_strobe, .rsp_product
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         back_busy_ff <= 1'b0;
      end else if (job_take) begin
         back_busy_ff <= 1'b1;
      end else if (rsp_strobe) begin
         back_busy_ff <= 1'b0;
      end
   end

   assign busy = front_busy || (back_busy_ff && job_valid);
endmodule

// ----- design/fpm_checker.sv -----
// fpm_checker: port-level checks of the fp32 multiplier
// depends on fp32_multiplier ports only
module fpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_product
);
   a_no_double_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back strobes");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not held");
   a_known_product: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_product)) else $error("unknown product");
   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_product[30:23] == 8'hFF && rsp_product[22:0] != 23'd0)
      |-> rsp_product == 32'h7FC0_0000) else $error("non-canonical nan");
endmodule

bind fp32_multiplier fpm_checker u_fpm_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_product
);

// ----- verif/fp32_multiplier_tb.sv -----
// fp32_multiplier_tb: self-checking testbench for the fp32 multiplier
// depends on fpm_pkg and the fp32_multiplier rtl; a product model and scoreboard
// class predict and check every rsp_product against the accepted operand pairs
module fp32_multiplier_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpm_pkg::*;

   localparam int N_RANDOM    = 1230;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 80;

   class product_board;
      logic [31:0] pending[$];
      int errors;
      int checked;

      function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
         logic [7:0] ea, eb;
         logic [22:0] fa, fb;
         logic sgn, a_inf, b_inf, a_zero, b_zero;
         logic [47:0] prod;
         logic [48:0] sum;
         int e;
         ea = a[30:23];
         eb = b[30:23];
         fa = a[22:0];
         fb = b[22:0];
         sgn = a[31] ^ b[31];
         a_inf = (ea == EXP_ONES) && (fa == 0);
         b_inf = (eb == EXP_ONES) && (fb == 0);
         a_zero = (ea == 0) && (fa == 0);
         b_zero = (eb == 0) && (fb == 0);
         if ((ea == EXP_ONES && fa != 0) || (eb == EXP_ONES && fb != 0))
            return QUIET_NAN;
         if ((a_inf && b_zero) || (a_zero && b_inf))
            return QUIET_NAN;
         if (a_inf || b_inf)
            return {sgn, EXP_ONES, 23'd0};
         if (a_zero || b_zero)
            return {sgn, 31'd0};
         prod = {24'd0, (ea != 0), fa} * {24'd0, (eb != 0), fb};
         e = int'(ea) + int'(eb) - EXP_BIAS;
         if (prod[47]) begin
            prod = prod >> 1;
            e++;
         end else begin
            while (!prod[46] && e > 0) begin
               prod = prod << 1;
               e--;
            end
         end
         if (e <= 0)
            e = 0;
         if (prod[22]) begin
            sum = {1'b0, prod} + 49'(1 << 22);
            prod = sum[47:0];
            prod[21:0] = '0;
            if (prod[47]) begin
               prod = prod >> 1;
               e++;
            end
         end
         if (e >= 255)
            return {sgn, EXP_ONES, 23'd0};
         return {sgn, e[7:0], prod[45:23]};
      endfunction

      function void note_request(logic [31:0] a, logic [31:0] b);
         pending.push_back(fmul(a, b));
      endfunction

      function void check_product(logic [31:0] got);
         logic [31:0] want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected product %h", $time, got);
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            errors++;
            $display("%0t: product mismatch expected %h actual %h", $time, want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic busy;
   logic rsp_strobe;
   logic [31:0] rsp_product;

   product_board board;
   int idle_cycles;
   int sent;

   fp32_multiplier dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_product(rsp_product)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_product(rsp_product);
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_request(logic [31:0] a, logic [31:0] b, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(a, b);
      sent++;
   endtask

   task automatic end_requests();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[30:23] = 8'h00;
         1: v[30:23] = EXP_ONES;
         2: v[30:0] = '0;
         3: v[30:23] = 8'($urandom_range(0, 12));
         4: v[30:23] = 8'($urandom_range(240, 254));
         5: v[22:0] = $urandom_range(0, 3) == 0 ? 23'h7FFFFF : 23'($urandom_range(0, 7));
         default: v[30:23] = 8'($urandom_range(64, 190));
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] corners[14];
      board = new();
      start = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      idle_cycles = 0;
      sent = 0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      corners = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                  32'h7FC0_0000, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
                  32'h3F80_0000, 32'hBFFF_FFFF, 32'h7F7F_FFFF, 32'h0080_0000,
                  32'h3FFF_FFFF, 32'h1F80_0000};
      for (int i = 0; i < 14; i++)
         send_request(corners[i], corners[(i * 5 + 3) % 14], 1'b0);
      send_request(32'h7F80_0000, 32'h0000_0000, 1'b0);
      send_request(32'h8000_0000, 32'hFF80_0000, 1'b0);
      send_request(32'h7F7F_FFFF, 32'h4000_0000, 1'b0);
      send_request(32'h3F80_0001, 32'h3F7F_FFFF, 1'b0);
      send_request(32'h0040_0000, 32'h3F00_0000, 1'b0);
      send_request(32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0);
      send_request(32'hFFFF_FFFF, 32'h3F80_0000, 1'b0);
      send_request(32'h2000_0000, 32'h2000_0000, 1'b0);

      end_requests();
      while (board.pending.size() != 0) @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            end_requests();
            while (board.pending.size() != 0) @(posedge clock);
         end
         send_request(random_operand(), random_operand(), (i / 100) % 3 != 1);
      end

      end_requests();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d requests sent, %0d products checked: special operands, subnormals,",
               sent, board.checked);
      $display("rounding carry, overflow and underflow flush, with random gaps");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
